### rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fpj_pkg.sv
// Shared types, constants and helper functions of the Fitch parsimony join engine.
// No dependencies; compile this file before all modules.
package fpj_pkg;

	localparam int WORD_BITS     = 64;
	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_MAX_WORDS = 64;
	localparam int DEF_MAX_SITES = 2048;
	localparam int LANES         = 32;
	localparam int LANE_AW       = 5;
	localparam int WEIGHT_W      = 32;
	localparam int SCORE_W       = 48;
	localparam int COUNT_W       = 12;
	localparam int NIB_W         = 6;
	localparam int WCNT_W        = 7;
	localparam int CFG_W         = 7;
	localparam int CFG_IDX_W     = 1;

	typedef enum logic [1:0] {
		OP_LOAD_WORD   = 2'd0,
		OP_LOAD_WEIGHT = 2'd1,
		OP_JOIN        = 2'd2,
		OP_READ_CLEAR  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS  = 1'd1;

	localparam logic [NIB_W-1:0]  NIB_RESET  = 6'd4;
	localparam logic [WCNT_W-1:0] WCNT_RESET = 7'd1;

	// Nibble width with out-of-range settings clamped to 2..32.
	function automatic logic [NIB_W-1:0] eff_nibble(input logic [NIB_W-1:0] v);
		if (v < 6'd2)
			return 6'd2;
		else if (v > 6'd32)
			return 6'd32;
		else
			return v;
	endfunction

	// Whole slots in one 64-bit word for a given nibble width.
	function automatic logic [NIB_W-1:0] slots_of(input logic [NIB_W-1:0] nw);
		logic [NIB_W-1:0] s;
		case (nw)
			6'd2:  s = 6'd32;
			6'd3:  s = 6'd21;
			6'd4:  s = 6'd16;
			6'd5:  s = 6'd12;
			6'd6:  s = 6'd10;
			6'd7:  s = 6'd9;
			6'd8:  s = 6'd8;
			6'd9:  s = 6'd7;
			6'd10: s = 6'd6;
			6'd11, 6'd12: s = 6'd5;
			6'd13, 6'd14, 6'd15, 6'd16: s = 6'd4;
			6'd17, 6'd18, 6'd19, 6'd20, 6'd21: s = 6'd3;
			default: s = 6'd2;
		endcase
		return s;
	endfunction

	// Bit mask of slot k, or zero when the slot does not fit in the word.
	function automatic logic [WORD_BITS-1:0] slot_mask(input logic [NIB_W-1:0] nw, input int k);
		int ends;
		logic [WORD_BITS-1:0] m;
		ends = (k + 1) * int'(nw);
		m    = '0;
		if (ends <= WORD_BITS)
			m = ((64'(1) << nw) - 64'(1)) << (k * int'(nw));
		return m;
	endfunction

endpackage

### rtl/fpj_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
module fpj_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

### rtl/fitch_parsimony_join.sv
// Fitch parsimony join engine: a single row walker over the node memory and banked weights.
// Depends on fpj_pkg and fpj_ram.
//
// The engine keeps every node row in a synchronous node memory (two copies, one per child
// read) and the site weights in 32 banks, bank j holding sites whose number is j modulo 32.
// Each input transaction produces exactly one output transaction. Load and read-and-clear
// transactions are answered in the next cycle. A join with nodes in range walks its rows
// word by word: the node memory delivers one row word per child per cycle, and every
// word's slot weights come out of the banks in that same cycle; each word then passes
// through the slot, adder tree and score pipeline. The engine holds one transaction at a
// time and takes the next as soon as its result register is free or being emptied. Node
// rows and weights are never cleared: a row or weight read before it was written yields
// unspecified data. The unrooted step (right child equal to the parent) needs no
// interlock, since word w is written back only after it has been read and before word
// w+1 is ever rewritten. The score saturates at 2^48-1 and the count of empty
// intersections at 4095.
module fitch_parsimony_join #(
	parameter int MAX_NODES = fpj_pkg::DEF_MAX_NODES,
	parameter int MAX_WORDS = fpj_pkg::DEF_MAX_WORDS,
	parameter int MAX_SITES = fpj_pkg::DEF_MAX_SITES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpj_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [9:0]                    target_node,
	input  logic [9:0]                    left_node,
	input  logic [9:0]                    right_node,
	input  logic [5:0]                    word_index,
	input  logic [10:0]                   site_index,
	input  logic [63:0]                   state_word,
	input  logic [31:0]                   site_weight,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fpj_pkg::SCORE_W-1:0]   score,
	output logic [fpj_pkg::COUNT_W-1:0]   sites_added
);
	import fpj_pkg::*;

	localparam int NODE_AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int WORD_AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int NODE_DEPTH = MAX_NODES * (2 ** WORD_AW);
	localparam int ADDR_W     = NODE_AW + WORD_AW;
	localparam int WC_W       = $clog2(MAX_WORDS + 1);
	localparam int BANK_DEPTH = (MAX_SITES + LANES - 1) / LANES;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int SITE_W     = $clog2(MAX_WORDS * LANES + LANES);
	localparam int PART_W     = WEIGHT_W + 2;
	localparam int SUM_W      = WEIGHT_W + LANE_AW;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t                state_q;
	logic [NIB_W-1:0]      nw_cfg_q;
	logic [WCNT_W-1:0]     wc_cfg_q;
	logic [NIB_W-1:0]      nw_q;
	logic [NIB_W-1:0]      slots_q;
	logic [WC_W-1:0]       words_q;
	logic [WC_W-1:0]       word_q;
	logic [SITE_W-1:0]     start_q;
	logic [NODE_AW-1:0]    left_q;
	logic [NODE_AW-1:0]    right_q;
	logic [NODE_AW-1:0]    par_q;
	logic [SCORE_W-1:0]    score_q;
	logic [COUNT_W-1:0]    cnt_q;
	logic                  out_valid_q;
	logic [SCORE_W-1:0]    score_out_q;
	logic [COUNT_W-1:0]    added_out_q;

	// Pipeline: s1 = memory data, s2 = masked weights, s3 = partial sums, s4 = word sum.
	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [WORD_AW-1:0]    w_s1;
	logic [SITE_W-1:0]     start_s1;
	logic [WEIGHT_W-1:0]   wt_s2 [LANES];
	logic [LANE_AW:0]      cnt_s2;
	logic [PART_W-1:0]     part_s3 [LANES/4];
	logic [SUM_W-1:0]      sum_s4;

	logic                  accept;
	logic                  nodes_ok;
	logic                  join_start;
	logic                  finish;
	logic                  issue;
	logic [WC_W-1:0]       eff_words;

	logic                  node_we;
	logic [ADDR_W-1:0]     node_waddr;
	logic [WORD_BITS-1:0]  node_wdata;
	logic [WORD_BITS-1:0]  x_data, y_data;
	logic [WEIGHT_W-1:0]   bank_rdata [LANES];
	logic [BANK_AW-1:0]    bank_raddr [LANES];
	logic [LANES-1:0]      bank_we;
	logic [WORD_BITS-1:0]  join_word;
	logic [LANES-1:0]      empty;
	logic [WEIGHT_W-1:0]   slot_wt [LANES];

	assign in_ready    = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept      = in_valid && in_ready;
	assign nodes_ok    = (32'(target_node) < MAX_NODES) && (32'(left_node) < MAX_NODES)
	                     && (32'(right_node) < MAX_NODES);
	assign join_start  = accept && (operation == OP_JOIN) && nodes_ok;
	assign issue       = (state_q == ST_RUN);
	assign finish      = (state_q == ST_DRAIN) && !(v_s1 || v_s2 || v_s3 || v_s4)
	                     && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign score       = score_out_q;
	assign sites_added = added_out_q;

	always_comb begin
		if (wc_cfg_q == '0)
			eff_words = WC_W'(1);
		else if (32'(wc_cfg_q) > MAX_WORDS)
			eff_words = WC_W'(MAX_WORDS);
		else
			eff_words = WC_W'(wc_cfg_q);
	end

	// Write port of the node memory: the join write-back, otherwise a host word load.
	always_comb begin
		if (v_s1) begin
			node_we    = 1'b1;
			node_waddr = {par_q, w_s1};
			node_wdata = join_word;
		end else begin
			node_we    = accept && (operation == OP_LOAD_WORD) && (32'(target_node) < MAX_NODES)
			             && (32'(word_index) < MAX_WORDS);
			node_waddr = {NODE_AW'(target_node), WORD_AW'(word_index)};
			node_wdata = state_word;
		end
	end

	fpj_ram #(.WIDTH(WORD_BITS), .DEPTH(NODE_DEPTH)) u_node_left (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(issue), .raddr({left_q, word_q[WORD_AW-1:0]}), .rdata(x_data)
	);

	fpj_ram #(.WIDTH(WORD_BITS), .DEPTH(NODE_DEPTH)) u_node_right (
		.clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.re(issue), .raddr({right_q, word_q[WORD_AW-1:0]}), .rdata(y_data)
	);

	// The sites of one word form a run of at most 32, so each bank is read at most once.
	for (genvar j = 0; j < LANES; j++) begin : g_bank
		assign bank_we[j]    = accept && (operation == OP_LOAD_WEIGHT)
		                       && (32'(site_index) < MAX_SITES)
		                       && (site_index[LANE_AW-1:0] == LANE_AW'(j));
		assign bank_raddr[j] = BANK_AW'((start_q >> LANE_AW)
		                       + SITE_W'(LANE_AW'(j) < start_q[LANE_AW-1:0]));

		fpj_ram #(.WIDTH(WEIGHT_W), .DEPTH(BANK_DEPTH)) u_weight (
			.clk(clk), .we(bank_we[j]), .waddr(BANK_AW'(site_index >> LANE_AW)),
			.wdata(site_weight), .re(issue), .raddr(bank_raddr[j]), .rdata(bank_rdata[j])
		);
	end

	// Slot logic on the word pair just read.
	always_comb begin
		logic [WORD_BITS-1:0] m;
		logic [LANE_AW-1:0]   lane;
		logic                 site_ok;
		join_word = x_data & y_data;
		for (int k = 0; k < LANES; k++) begin
			m        = slot_mask(nw_q, k);
			empty[k] = (m != '0) && ((x_data & y_data & m) == '0);
			if (empty[k])
				join_word = join_word | ((x_data | y_data) & m);
			lane       = start_s1[LANE_AW-1:0] + LANE_AW'(k);
			site_ok    = (32'(start_s1) + k) < MAX_SITES;
			slot_wt[k] = (empty[k] && site_ok) ? bank_rdata[lane] : '0;
		end
	end

	always_ff @(posedge clk) begin
		w_s1     <= word_q[WORD_AW-1:0];
		start_s1 <= start_q;
		for (int k = 0; k < LANES; k++)
			wt_s2[k] <= slot_wt[k];
		cnt_s2 <= (LANE_AW + 1)'($countones(empty));
		for (int i = 0; i < LANES / 4; i++)
			part_s3[i] <= PART_W'(wt_s2[4*i]) + PART_W'(wt_s2[4*i+1])
			              + PART_W'(wt_s2[4*i+2]) + PART_W'(wt_s2[4*i+3]);
		sum_s4 <= SUM_W'(part_s3[0]) + SUM_W'(part_s3[1]) + SUM_W'(part_s3[2])
		          + SUM_W'(part_s3[3]) + SUM_W'(part_s3[4]) + SUM_W'(part_s3[5])
		          + SUM_W'(part_s3[6]) + SUM_W'(part_s3[7]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nw_cfg_q <= NIB_RESET;
			wc_cfg_q <= WCNT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NIBBLE: nw_cfg_q <= cfg_data[NIB_W-1:0];
				REG_WORDS:  wc_cfg_q <= cfg_data[WCNT_W-1:0];
				default:    ;
			endcase
		end
	end

	// Sequencer, score and count accumulators, and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		logic [SCORE_W:0]   ssum;
		logic [COUNT_W:0]   csum;
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nw_q        <= NIB_RESET;
			slots_q     <= '0;
			words_q     <= '0;
			word_q      <= '0;
			start_q     <= '0;
			left_q      <= '0;
			right_q     <= '0;
			par_q       <= '0;
			score_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			score_out_q <= '0;
			added_out_q <= '0;
		end else begin
			ssum = {1'b0, score_q} + (SCORE_W + 1)'(sum_s4);
			csum = {1'b0, cnt_q} + (COUNT_W + 1)'(cnt_s2);
			if (v_s4)
				score_q <= ssum[SCORE_W] ? '1 : ssum[SCORE_W-1:0];
			if (v_s2)
				cnt_q <= csum[COUNT_W] ? '1 : csum[COUNT_W-1:0];

			unique case (state_q)
				ST_IDLE: begin
					if (join_start) begin
						state_q <= ST_RUN;
						nw_q    <= eff_nibble(nw_cfg_q);
						slots_q <= slots_of(eff_nibble(nw_cfg_q));
						words_q <= eff_words;
						word_q  <= '0;
						start_q <= '0;
						left_q  <= NODE_AW'(left_node);
						right_q <= NODE_AW'(right_node);
						par_q   <= NODE_AW'(target_node);
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					word_q  <= word_q + WC_W'(1);
					start_q <= start_q + SITE_W'(slots_q);
					if (word_q + WC_W'(1) == words_q)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (finish)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			priority if (finish) begin
				out_valid_q <= 1'b1;
				score_out_q <= score_q;
				added_out_q <= cnt_q;
			end else if (accept && !join_start) begin
				out_valid_q <= 1'b1;
				score_out_q <= score_q;
				added_out_q <= '0;
				if (operation == OP_READ_CLEAR)
					score_q <= '0;
			end else begin
				if (out_ready)
					out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/fpj_checker.sv
// Port-level checker for the Fitch parsimony join engine, bound to its top level.
// Depends on fpj_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpj_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [1:0]                  operation,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fpj_pkg::SCORE_W-1:0] score,
	input logic [fpj_pkg::COUNT_W-1:0] sites_added
);
	import fpj_pkg::*;

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(score) && $stable(sites_added), "stalled result changed")
	`ASSERT_NXT(a_quick_result, clk, arst_n, in_valid && in_ready && operation != OP_JOIN, out_valid && sites_added == '0, "non-join transaction gave no prompt result")
	`ASSERT_NXT(a_join_busy, clk, arst_n, in_valid && in_ready && operation == OP_JOIN, !in_ready, "transaction taken during a join")
	`ASSERT_IMP(a_no_overrun, clk, arst_n, out_valid && in_ready, out_ready, "input taken while result blocked")

endmodule

bind fitch_parsimony_join fpj_checker u_fpj_checker (.*);

### sim/fpj_checker.sv
// Checker for the Fitch parsimony join engine: follows the configuration port and both
// channels, predicts every result and compares it field by field. Depends on fpj_pkg.
module fpj_scoreboard (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [fpj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpj_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [9:0]                    target_node,
	input  logic [9:0]                    left_node,
	input  logic [9:0]                    right_node,
	input  logic [5:0]                    word_index,
	input  logic [10:0]                   site_index,
	input  logic [63:0]                   state_word,
	input  logic [31:0]                   site_weight,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [fpj_pkg::SCORE_W-1:0]   score,
	input  logic [fpj_pkg::COUNT_W-1:0]   sites_added,
	output int                            errors,
	output int                            pending
);
	import fpj_pkg::*;

	localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [COUNT_W-1:0] added;
	} outcome_t;

	logic [63:0]         row_words [0:DEF_MAX_NODES*DEF_MAX_WORDS-1];
	logic [31:0]         weights [0:DEF_MAX_SITES-1];
	logic [SCORE_W-1:0]  running_score;
	logic [NIB_W-1:0]    nibble_reg;
	logic [WCNT_W-1:0]   words_reg;
	outcome_t            awaited_q [$];

	// Fitch step over the row: intersection where it is non-empty, otherwise the union
	// plus that site's weight on the saturating score.
	function automatic logic [COUNT_W-1:0] fitch_join(input int par, input int lft,
			input int rgt);
		int nw, nwords, slots, site;
		logic [63:0] x, y, r, mask, a, b, sum;
		int cnt;
		nw     = (nibble_reg < 2) ? 2 : (nibble_reg > 32) ? 32 : int'(nibble_reg);
		nwords = (words_reg == 0) ? 1 : (words_reg > DEF_MAX_WORDS) ? DEF_MAX_WORDS :
			int'(words_reg);
		slots  = WORD_BITS / nw;
		mask   = (64'd1 << nw) - 64'd1;
		cnt    = 0;
		for (int w = 0; w < nwords; w++) begin
			x = row_words[lft*DEF_MAX_WORDS + w];
			y = row_words[rgt*DEF_MAX_WORDS + w];
			r = x & y;
			for (int k = 0; k < slots; k++) begin
				a = (x >> (k*nw)) & mask;
				b = (y >> (k*nw)) & mask;
				if ((a & b) == 64'd0) begin
					r = r | ((a | b) << (k*nw));
					cnt++;
					site = slots*w + k;
					if (site < DEF_MAX_SITES) begin
						sum = 64'(running_score) + 64'(weights[site]);
						running_score = (sum > 64'(SCORE_SAT)) ? SCORE_SAT : sum[SCORE_W-1:0];
					end
				end
			end
			row_words[par*DEF_MAX_WORDS + w] = r;
		end
		return (cnt > 4095) ? 12'd4095 : COUNT_W'(cnt);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got, want;
		int       bad;
		if (!arst_n) begin
			running_score = '0;
			nibble_reg    = NIB_RESET;
			words_reg     = WCNT_RESET;
			awaited_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (cfg_write) begin
				if (cfg_index == REG_NIBBLE)
					nibble_reg = cfg_data[NIB_W-1:0];
				else if (cfg_index == REG_WORDS)
					words_reg = cfg_data[WCNT_W-1:0];
			end
			if (in_valid && in_ready) begin
				want.added = '0;
				case (op_t'(operation))
					OP_LOAD_WORD:
						row_words[int'(target_node)*DEF_MAX_WORDS + int'(word_index)] = state_word;
					OP_LOAD_WEIGHT:
						weights[site_index] = site_weight;
					OP_JOIN:
						want.added = fitch_join(int'(target_node), int'(left_node),
							int'(right_node));
					default: ;
				endcase
				want.score = running_score;
				if (op_t'(operation) == OP_READ_CLEAR)
					running_score = '0;
				awaited_q = {awaited_q, want};
			end
			if (out_valid && out_ready) begin
				got.score = score;
				got.added = sites_added;
				if (awaited_q.size() == 0) begin
					$display("%0t: result with nothing awaited: score %h sites_added %0d",
						$time, got.score, got.added);
					bad++;
				end else begin
					want = awaited_q.pop_front();
					if (got.score !== want.score) begin
						$display("%0t: score mismatch: expected %h, got %h",
							$time, want.score, got.score);
						bad++;
					end
					if (got.added !== want.added) begin
						$display("%0t: sites_added mismatch: expected %0d, got %0d",
							$time, want.added, got.added);
						bad++;
					end
				end
			end
			errors  <= errors + bad;
			pending <= awaited_q.size();
		end
	end

endmodule

### sim/tb_fitch_parsimony_join.sv
// Top of the testbench for the Fitch parsimony join engine: clock, reset, stimulus, verdict.
// Depends on fpj_pkg, fitch_parsimony_join and fpj_scoreboard.
module tb_fitch_parsimony_join;
	import fpj_pkg::*;

	// Every transaction of the engine is answered well inside this limit, so a
	// stretch this long without any transaction on either channel means a hang.
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 80;
	localparam int POOL_SIZE   = 8;
	localparam int SITE_BUDGET = 192;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_NIBBLE;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           operation = OP_READ_CLEAR;
	logic [9:0]           target_node = '0;
	logic [9:0]           left_node = '0;
	logic [9:0]           right_node = '0;
	logic [5:0]           word_index = '0;
	logic [10:0]          site_index = '0;
	logic [63:0]          state_word = '0;
	logic [31:0]          site_weight = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [SCORE_W-1:0]   score;
	logic [COUNT_W-1:0]   sites_added;
	int                   errors;
	int                   pending;

	// What the stimulus may legally read back: rows and weights that have been written.
	bit                   row_written [0:DEF_MAX_NODES*DEF_MAX_WORDS-1];
	bit                   weight_written [0:DEF_MAX_SITES-1];
	logic [9:0]           pool [POOL_SIZE];
	int                   cur_nibble = 4;
	int                   cur_words = 1;
	bit                   quiet = 1'b0;
	int                   sent = 0;
	int                   joins_sent = 0;
	int                   phases_run = 0;
	int                   idle_cycles = 0;

	always #5 clk = ~clk;

	fitch_parsimony_join DUT (.*);

	fpj_scoreboard u_scoreboard (.*);

	// Hang detection: cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired after %0d quiet cycles at %0t", STALL_LIMIT, $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: alternating bursts of readiness and stalls, always ready in the final phase.
	initial begin
		@(posedge arst_n);
		forever begin
			if (quiet || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// State words of several textures, so that both empty and non-empty intersections
	// turn up in plenty.
	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 4))
			0: return {$urandom, $urandom};
			1: return {$urandom, $urandom} & {$urandom, $urandom};
			2: return ~({$urandom, $urandom} & {$urandom, $urandom});
			3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return $urandom_range(0, 1) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Presents one transaction and returns at the clock edge that accepts it. The ready
	// line is looked at on the falling edge, where it is settled.
	task automatic push_item(input op_t op, input logic [9:0] tgt, input logic [9:0] lft,
			input logic [9:0] rgt, input logic [5:0] widx, input logic [10:0] sidx,
			input logic [63:0] sw, input logic [31:0] wt);
		int gap;
		gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation   <= op;
		target_node <= tgt;
		left_node   <= lft;
		right_node  <= rgt;
		word_index  <= widx;
		site_index  <= sidx;
		state_word  <= sw;
		site_weight <= wt;
		in_valid    <= 1'b1;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (op == OP_JOIN) begin
			joins_sent++;
			for (int w = 0; w < cur_words; w++)
				row_written[int'(tgt)*DEF_MAX_WORDS + w] = 1'b1;
		end
	endtask

	// Thin wrappers; the fields an operation ignores carry random junk.
	task automatic load_word(input logic [9:0] node, input logic [5:0] widx,
			input logic [63:0] sw);
		push_item(OP_LOAD_WORD, node, 10'($urandom), 10'($urandom), widx, 11'($urandom),
			sw, $urandom);
		row_written[int'(node)*DEF_MAX_WORDS + int'(widx)] = 1'b1;
	endtask

	task automatic load_weight(input logic [10:0] site, input logic [31:0] wt);
		push_item(OP_LOAD_WEIGHT, 10'($urandom), 10'($urandom), 10'($urandom), 6'($urandom),
			site, {$urandom, $urandom}, wt);
		weight_written[site] = 1'b1;
	endtask

	task automatic join_rows(input logic [9:0] par, input logic [9:0] lft,
			input logic [9:0] rgt);
		push_item(OP_JOIN, par, lft, rgt, 6'($urandom), 11'($urandom), {$urandom, $urandom},
			$urandom);
	endtask

	task automatic read_clear();
		push_item(OP_READ_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom), 6'($urandom),
			11'($urandom), {$urandom, $urandom}, $urandom);
	endtask

	// Holds the sender back until every result in flight has been delivered.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Writes both registers while the engine is idle, then makes sure every weight and
	// pool row that a join may read under the new setting has been written.
	task automatic set_phase(input logic [5:0] nib, input logic [6:0] wc);
		int need;
		drain();
		cfg_write <= 1'b1;
		cfg_index <= REG_NIBBLE;
		cfg_data  <= CFG_W'(nib);
		@(posedge clk);
		cfg_index <= REG_WORDS;
		cfg_data  <= CFG_W'(wc);
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_nibble = (nib < 2) ? 2 : (nib > 32) ? 32 : int'(nib);
		cur_words  = (wc == 0) ? 1 : (wc > DEF_MAX_WORDS) ? DEF_MAX_WORDS : int'(wc);
		need = (WORD_BITS / cur_nibble) * cur_words;
		if (need > DEF_MAX_SITES)
			need = DEF_MAX_SITES;
		for (int s = 0; s < need; s++)
			if (!weight_written[s])
				load_weight(11'(s), pick_weight());
		for (int p = 0; p < POOL_SIZE; p++)
			for (int w = 0; w < cur_words; w++)
				if (!row_written[int'(pool[p])*DEF_MAX_WORDS + w])
					load_word(pool[p], 6'(w), pick_word());
		phases_run++;
	endtask

	// Random traffic over the node pool: mostly joins, some unrooted, with loads and reads.
	task automatic random_traffic(input int count);
		logic [9:0] par, lft, rgt;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 1))
						load_word(pool[$urandom_range(0, POOL_SIZE-1)], 6'($urandom), pick_word());
					else
						load_word(10'($urandom), 6'($urandom), pick_word());
				end
				2: load_weight(11'($urandom), pick_weight());
				3: read_clear();
				default: begin
					lft = pool[$urandom_range(0, POOL_SIZE-1)];
					rgt = pool[$urandom_range(0, POOL_SIZE-1)];
					case ($urandom_range(0, 4))
						0: par = rgt;
						1: par = 10'($urandom);
						default: par = pool[$urandom_range(0, POOL_SIZE-1)];
					endcase
					join_rows(par, lft, rgt);
				end
			endcase
		end
	endtask

	initial begin
		logic [5:0] nib;
		logic [6:0] wc;
		logic [5:0] table_nib [10] = '{6'd0, 6'd2, 6'd3, 6'd5, 6'd7, 6'd32, 6'd17, 6'd9,
			6'd33, 6'd1};
		logic [6:0] table_wc [10] = '{7'd0, 7'd3, 7'd2, 7'd8, 7'd4, 7'd1, 7'd6, 7'd5,
			7'd20, 7'd2};

		pool[0] = 10'd0;
		pool[1] = 10'd1023;
		for (int p = 2; p < POOL_SIZE; p++)
			pool[p] = 10'($urandom_range(5, 999));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset setting (4-bit sets, one word per row): extreme
		// weights and words, an all-empty and an all-disjoint join, the unrooted step, and
		// a read that finds the score already cleared.
		read_clear();
		load_weight(11'd0, 32'd0);
		load_weight(11'd15, '1);
		for (int s = 1; s < 15; s++)
			load_weight(11'(s), $urandom);
		load_word(10'd0, 6'd0, '0);
		load_word(10'd1023, 6'd0, '1);
		load_word(10'd1, 6'd0, 64'h5555_5555_5555_5555);
		load_word(10'd2, 6'd0, 64'hAAAA_AAAA_AAAA_AAAA);
		join_rows(10'd3, 10'd0, 10'd1023);
		join_rows(10'd4, 10'd1, 10'd2);
		join_rows(10'd2, 10'd1, 10'd2);
		read_clear();
		read_clear();

		// Saturation: the narrowest sets (a register value below the range) over eight
		// words, all 256 sites disjoint and at full weight, joined until the score pins at
		// its maximum and stays there.
		for (int s = 0; s < 256; s++)
			load_weight(11'(s), '1);
		set_phase(6'd1, 7'd8);
		for (int w = 0; w < 8; w++) begin
			load_word(10'd1000, 6'(w), 64'h5555_5555_5555_5555);
			load_word(10'd1001, 6'(w), 64'hAAAA_AAAA_AAAA_AAAA);
		end
		read_clear();
		for (int j = 0; j < 264; j++)
			join_rows(10'd1002, 10'd1000, 10'd1001);
		read_clear();
		read_clear();

		// Random phases: a table of settings first, then random ones sized so that the
		// weights a join may touch stay within a modest budget. The last phase runs with
		// neither side idling.
		for (int ph = 0; ph < 14; ph++) begin
			if (ph < 10) begin
				nib = table_nib[ph];
				wc  = table_wc[ph];
			end else begin
				nib = 6'($urandom);
				wc  = 7'($urandom_range(0, SITE_BUDGET /
					(WORD_BITS / ((nib < 2) ? 2 : (nib > 32) ? 32 : int'(nib)))));
			end
			quiet = (ph == 13);
			set_phase(nib, wc);
			random_traffic(50);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d transactions, %0d of them joins, over %0d register settings,",
			sent, joins_sent, phases_run + 1);
		$display("including score saturation and register values beyond their ranges.");
		if (errors == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never delivered", errors, pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
